// ===== rtl/ibs_pkg.sv =====
// shared constants and types of the interval bucket search unit
`default_nettype none

package ibs_pkg;

   localparam int MAX_BUCKETS_DEF = 1024;

   localparam int KEY_W      = 64;
   localparam int SLOT_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_BUCKET_COUNT = REG_IDX_W'(0);

   typedef struct packed {
      logic valid;
      logic cmd;
      logic wen;
      logic active;
      logic hit;
   } ibs_flags_type;

   // a holds the key for a lookup or the low bound for a write
   typedef struct packed {
      logic [KEY_W-1:0] a;
      logic [KEY_W-1:0] b;
   } ibs_data_type;

endpackage

`default_nettype wire

// ===== rtl/ibs_if.sv =====
// request and response channel interfaces of the interval bucket search unit
`default_nettype none

interface ibs_req_if;
   import ibs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [SLOT_W-1:0]       entry_index;
   logic signed [KEY_W-1:0] low_bound;
   logic signed [KEY_W-1:0] high_bound;
   logic signed [KEY_W-1:0] search_value;

   modport source (
      output valid, cmd, entry_index, low_bound, high_bound, search_value,
      input  ready
   );
   modport sink (
      input  valid, cmd, entry_index, low_bound, high_bound, search_value,
      output ready
   );
endinterface

interface ibs_rsp_if;
   import ibs_pkg::*;

   logic              valid;
   logic              ready;
   logic              hit;
   logic [SLOT_W-1:0] bucket_index;

   modport source (
      output valid, hit, bucket_index,
      input  ready
   );
   modport sink (
      input  valid, hit, bucket_index,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/ibs_stage.sv =====
// one level of the search pipeline: evaluates a probe, issues the next read
`default_nettype none

module ibs_stage #(
   parameter int MAX_BUCKETS = ibs_pkg::MAX_BUCKETS_DEF,
   parameter bit FIRST       = 1'b0,
   parameter bit HAS_MEM     = 1'b1,
   localparam int AW = $clog2(MAX_BUCKETS),
   localparam int CW = $clog2(MAX_BUCKETS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [CW-1:0]                 n,
   input  ibs_pkg::ibs_flags_type        in_flags,
   input  ibs_pkg::ibs_data_type         in_data,
   input  logic [AW-1:0]                 in_slot,
   input  logic [CW-1:0]                 in_lo,
   input  logic [CW-1:0]                 in_hx,
   input  logic [AW-1:0]                 in_mid,
   input  logic [AW-1:0]                 in_idx,
   input  logic [ibs_pkg::KEY_W-1:0]     in_low_rd,
   input  logic [ibs_pkg::KEY_W-1:0]     in_high_rd,
   output ibs_pkg::ibs_flags_type        out_flags,
   output ibs_pkg::ibs_data_type         out_keys,
   output logic [AW-1:0]                 out_slot,
   output logic [CW-1:0]                 out_lo,
   output logic [CW-1:0]                 out_hx,
   output logic [AW-1:0]                 out_mid,
   output logic [AW-1:0]                 out_idx,
   output logic [ibs_pkg::KEY_W-1:0]     out_low_rd,
   output logic [ibs_pkg::KEY_W-1:0]     out_high_rd
);
   import ibs_pkg::*;

   ibs_flags_type flags_in, flags_ff;
   ibs_data_type  data_ff;
   logic [AW-1:0] slot_ff, mid_ff, idx_ff;
   logic [CW-1:0] lo_ff, hx_ff;
   logic [CW-1:0] lo_in, hx_in;
   logic [AW-1:0] mid_in, idx_in;
   logic [CW:0]   mid_sum;
   logic          key_lt_low, key_lt_high;
   logic          mem_we;

   always_comb begin
      flags_in    = in_flags;
      lo_in       = in_lo;
      hx_in       = in_hx;
      idx_in      = in_idx;
      key_lt_low  = $signed(in_data.a) < $signed(in_low_rd);
      key_lt_high = $signed(in_data.a) < $signed(in_high_rd);
      if (in_flags.cmd == CMD_LOOKUP) begin
         if (FIRST) begin
            // range check against the first low bound and the last high bound
            flags_in.active = (n != '0) && !key_lt_low && key_lt_high;
            lo_in           = '0;
            hx_in           = n;
         end else if (in_flags.active) begin
            if (!key_lt_low && key_lt_high) begin
               flags_in.hit    = 1'b1;
               flags_in.active = 1'b0;
               idx_in          = in_mid;
            end else begin
               if (key_lt_low) begin
                  hx_in = CW'(in_mid);
               end else begin
                  lo_in = CW'(in_mid) + CW'(1);
               end
               if (lo_in >= hx_in) begin
                  flags_in.active = 1'b0;
               end
            end
         end
      end
      // hx is exclusive, so the probe is floor((lo + hx - 1) / 2)
      mid_sum = (CW+1)'(lo_in) + (CW+1)'(hx_in) - (CW+1)'(1);
      mid_in  = AW'(mid_sum >> 1);
   end

   assign mem_we = in_flags.valid && (in_flags.cmd == CMD_WRITE) && in_flags.wen;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= in_data;
         slot_ff <= in_slot;
         lo_ff   <= lo_in;
         hx_ff   <= hx_in;
         mid_ff  <= mid_in;
         idx_ff  <= idx_in;
      end
   end

   generate
      if (HAS_MEM) begin : g_mem
         logic [2*KEY_W-1:0] bounds_mem [MAX_BUCKETS];
         logic [2*KEY_W-1:0] rd_ff;

         // writes pass down the pipe so each copy sees them in item order
         always_ff @(posedge clock) begin
            if (advance) begin
               if (mem_we) begin
                  bounds_mem[in_slot] <= {in_data.a, in_data.b};
               end
               rd_ff <= bounds_mem[mid_in];
            end
         end

         assign out_low_rd  = rd_ff[2*KEY_W-1:KEY_W];
         assign out_high_rd = rd_ff[KEY_W-1:0];
      end else begin : g_nomem
         assign out_low_rd  = mem_we ? in_data.a : '0;
         assign out_high_rd = mem_we ? in_data.b : '0;
      end
   endgenerate

   assign out_flags = flags_ff;
   assign out_keys  = data_ff;
   assign out_slot  = slot_ff;
   assign out_lo    = lo_ff;
   assign out_hx    = hx_ff;
   assign out_mid   = mid_ff;
   assign out_idx   = idx_ff;

endmodule

`default_nettype wire

// ===== rtl/interval_bucket_search_unit.sv =====
// Interval bucket search unit: maps a signed 64-bit key to the index of the
// sorted half-open interval [low, high) that holds it.
// req channel: cmd 0 writes one interval's bounds into entry_index and gives
// no result; cmd 1 searches the first bucket_count intervals and gives one
// rsp transfer with hit and bucket_index (zero on a miss).
// csr port: APB-style, bucket_count at byte address 0, pready tied high.
// Throughput: one item per cycle while rsp is not stalled. An input stage
// reads the range-check table copies, the first search stage checks the
// range and each later stage runs one binary-search level; every stage but
// the last has its own copy of the bounds table. A write follows the same
// path so every table copy sees items in order.
// Reset clears bucket_count and all pipeline valid bits; the table contents
// are undefined until written. When rsp is stalled the whole pipeline holds
// and req.ready drops; nothing is lost or repeated. The user must change
// bucket_count only while the unit is idle; the unit does not enforce it.
`default_nettype none

module interval_bucket_search_unit #(
   parameter int MAX_BUCKETS = ibs_pkg::MAX_BUCKETS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ibs_req_if.sink                         req,
   ibs_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ibs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ibs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ibs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import ibs_pkg::*;

   localparam int AW = $clog2(MAX_BUCKETS);
   localparam int CW = $clog2(MAX_BUCKETS + 1);
   localparam int P  = CW;
   localparam int NS = P + 2;

   // configuration
   logic [COUNT_W-1:0] count_ff;
   logic [CW-1:0]      count_n;
   logic               csr_wr, csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_paddr[CSR_ADDR_W-1:2] == REG_BUCKET_COUNT;
   assign csr_prdata = csr_sel ? CSR_DATA_W'(count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr && csr_sel) begin
         count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   assign count_n = (32'(count_ff) > 32'(MAX_BUCKETS)) ? CW'(MAX_BUCKETS) : CW'(count_ff);

   // handshake: one global advance for the whole pipe
   logic advance, accept, slot_ok;

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;
   assign accept    = req.valid && advance;
   assign slot_ok   = 32'(req.entry_index) < 32'(MAX_BUCKETS);

   // input stage with the range-check table copies
   ibs_flags_type      flags0_ff;
   ibs_data_type       data0_ff;
   logic [AW-1:0]      slot0_ff;
   logic [KEY_W-1:0]   low0_rd_ff, high0_rd_ff;
   logic [KEY_W-1:0]   low0_mem  [MAX_BUCKETS];
   logic [KEY_W-1:0]   high0_mem [MAX_BUCKETS];

   always_ff @(posedge clock) begin
      if (reset) begin
         flags0_ff <= '0;
      end else if (advance) begin
         flags0_ff.valid  <= req.valid;
         flags0_ff.cmd    <= req.cmd;
         flags0_ff.wen    <= slot_ok;
         flags0_ff.active <= 1'b0;
         flags0_ff.hit    <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data0_ff.a <= (req.cmd == CMD_LOOKUP) ? req.search_value : req.low_bound;
         data0_ff.b <= req.high_bound;
         slot0_ff   <= AW'(req.entry_index);
         if (accept && (req.cmd == CMD_WRITE) && slot_ok) begin
            low0_mem[AW'(req.entry_index)]  <= req.low_bound;
            high0_mem[AW'(req.entry_index)] <= req.high_bound;
         end
         low0_rd_ff  <= low0_mem[AW'(0)];
         high0_rd_ff <= high0_mem[AW'(count_n - CW'(1))];
      end
   end

   // search levels
   ibs_flags_type    st_flags   [NS];
   ibs_data_type     st_data    [NS];
   logic [AW-1:0]    st_slot    [NS];
   logic [CW-1:0]    st_lo      [NS];
   logic [CW-1:0]    st_hx      [NS];
   logic [AW-1:0]    st_mid     [NS];
   logic [AW-1:0]    st_idx     [NS];
   logic [KEY_W-1:0] st_low_rd  [NS];
   logic [KEY_W-1:0] st_high_rd [NS];

   assign st_flags[0]   = flags0_ff;
   assign st_data[0]    = data0_ff;
   assign st_slot[0]    = slot0_ff;
   assign st_lo[0]      = '0;
   assign st_hx[0]      = '0;
   assign st_mid[0]     = '0;
   assign st_idx[0]     = '0;
   assign st_low_rd[0]  = low0_rd_ff;
   assign st_high_rd[0] = high0_rd_ff;

   generate
      for (genvar k = 0; k <= P; k++) begin : g_stage
         ibs_stage #(
            .MAX_BUCKETS (MAX_BUCKETS),
            .FIRST       (k == 0),
            .HAS_MEM     (k < P)
         ) u_stage (
            .clock       (clock),
            .reset       (reset),
            .advance     (advance),
            .n           (count_n),
            .in_flags    (st_flags[k]),
            .in_data     (st_data[k]),
            .in_slot     (st_slot[k]),
            .in_lo       (st_lo[k]),
            .in_hx       (st_hx[k]),
            .in_mid      (st_mid[k]),
            .in_idx      (st_idx[k]),
            .in_low_rd   (st_low_rd[k]),
            .in_high_rd  (st_high_rd[k]),
            .out_flags   (st_flags[k+1]),
            .out_keys    (st_data[k+1]),
            .out_slot    (st_slot[k+1]),
            .out_lo      (st_lo[k+1]),
            .out_hx      (st_hx[k+1]),
            .out_mid     (st_mid[k+1]),
            .out_idx     (st_idx[k+1]),
            .out_low_rd  (st_low_rd[k+1]),
            .out_high_rd (st_high_rd[k+1])
         );
      end
   endgenerate

   // last stage register doubles as the result register
   assign rsp.valid        = st_flags[NS-1].valid && (st_flags[NS-1].cmd == CMD_LOOKUP);
   assign rsp.hit          = st_flags[NS-1].hit;
   assign rsp.bucket_index = st_flags[NS-1].hit ? SLOT_W'(st_idx[NS-1]) : '0;

`ifndef SYNTHESIS
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flags0_ff))
      else $error("input stage changed while the pipeline was stalled");

   a_search_done: assert property (@(posedge clock) disable iff (reset)
      st_flags[NS-1].valid && (st_flags[NS-1].cmd == CMD_LOOKUP) |-> !st_flags[NS-1].active)
      else $error("lookup left the last level with its search still open");

   a_write_inert: assert property (@(posedge clock) disable iff (reset)
      st_flags[1].valid && (st_flags[1].cmd == CMD_WRITE)
         |-> !st_flags[1].active && !st_flags[1].hit)
      else $error("write item picked up search state");
`endif

endmodule

`default_nettype wire

// ===== test/interval_bucket_search_unit_tb.sv =====
// testbench of the interval bucket search unit: directed table, then random phases
module interval_bucket_search_unit_tb;
   import ibs_pkg::*;

   localparam int TABLE_DEPTH  = MAX_BUCKETS_DEF;
   localparam int DRAIN_CYCLES = 16;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 55;
   localparam logic [CSR_ADDR_W-1:0] COUNT_ADDR = {REG_BUCKET_COUNT, 2'b00};
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   typedef struct {
      logic                    cmd;
      logic [SLOT_W-1:0]       slot;
      logic signed [KEY_W-1:0] low;
      logic signed [KEY_W-1:0] high;
      logic signed [KEY_W-1:0] key;
   } bucket_req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] idx;
   } bucket_hit_type;

   typedef enum {ROW_ITEM, ROW_COUNT} row_kind_type;

   typedef struct {
      row_kind_type   kind;
      bucket_req_type item;
      bit             typed;
      bucket_hit_type want;
      int unsigned    count_val;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ibs_req_if req_ch();
   ibs_rsp_if rsp_ch();

   interval_bucket_search_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor copy of the interval table and the count register
   logic signed [KEY_W-1:0] low_tab [TABLE_DEPTH];
   logic signed [KEY_W-1:0] high_tab [TABLE_DEPTH];
   bit                      slot_loaded [TABLE_DEPTH];
   int unsigned             bucket_count_reg;
   bucket_hit_type          pending_hits[$];
   plan_row_type            plan[$];
   int                      errors;
   int                      idle_pct;
   int                      stall_pct;
   int                      quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] rand_bits(input int bits);
      return rand_key() >> (KEY_W - bits);
   endfunction

   function automatic bucket_hit_type locate_bucket(input logic signed [KEY_W-1:0] key);
      int             n;
      int             lo_i;
      int             hi_i;
      int             mid;
      bucket_hit_type r;
      r = '0;
      n = (bucket_count_reg > TABLE_DEPTH) ? TABLE_DEPTH : bucket_count_reg;
      if (n == 0) return r;
      if (key < low_tab[0] || key >= high_tab[n-1]) return r;
      lo_i = 0;
      hi_i = n - 1;
      while (lo_i <= hi_i) begin
         mid = (lo_i + hi_i) / 2;
         if (key >= low_tab[mid] && key < high_tab[mid]) begin
            r.hit = 1'b1;
            r.idx = SLOT_W'(mid);
            return r;
         end
         if (key < low_tab[mid]) hi_i = mid - 1;
         else lo_i = mid + 1;
      end
      return r;
   endfunction

   task automatic plan_item(input logic cmd, input int slot,
                            input logic signed [KEY_W-1:0] low, high, key,
                            input bit typed, input logic hit, input int idx);
      plan_row_type row;
      row.kind      = ROW_ITEM;
      row.item.cmd  = cmd;
      row.item.slot = SLOT_W'(slot);
      row.item.low  = low;
      row.item.high = high;
      row.item.key  = key;
      row.typed     = typed;
      row.want.hit  = hit;
      row.want.idx  = SLOT_W'(idx);
      row.count_val = 0;
      plan.push_back(row);
   endtask

   task automatic plan_count(input int unsigned value);
      plan_row_type row;
      row.kind      = ROW_COUNT;
      row.item.cmd  = CMD_WRITE;
      row.item.slot = '0;
      row.item.low  = '0;
      row.item.high = '0;
      row.item.key  = '0;
      row.typed     = 1'b0;
      row.want      = '0;
      row.count_val = value;
      plan.push_back(row);
   endtask

   // one transfer on the request channel, then the predictor takes the item
   task automatic send_req(input bucket_req_type it, input bit typed,
                           input bucket_hit_type want);
      int gap;
      gap = 0;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= it.cmd;
      req_ch.entry_index  <= it.slot;
      req_ch.low_bound    <= it.low;
      req_ch.high_bound   <= it.high;
      req_ch.search_value <= it.key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (it.cmd == CMD_WRITE) begin
         low_tab[it.slot]     = it.low;
         high_tab[it.slot]    = it.high;
         slot_loaded[it.slot] = 1'b1;
      end else begin
         pending_hits.push_back(typed ? want : locate_bucket(it.key));
      end
   endtask

   // the count may change only with the pipeline empty, writes included
   task automatic set_bucket_count(input int unsigned value);
      req_ch.valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= COUNT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      bucket_count_reg = value;
   endtask

   always @(posedge clock) begin
      bucket_hit_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_hits.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual hit %0b bucket_index %0d",
                        $time, rsp_ch.hit, rsp_ch.bucket_index);
               errors++;
            end else begin
               want = pending_hits.pop_front();
               if (rsp_ch.hit !== want.hit) begin
                  $display("%0t: hit: expected %0b, actual %0b", $time, want.hit, rsp_ch.hit);
                  errors++;
               end
               if (rsp_ch.bucket_index !== want.idx) begin
                  $display("%0t: bucket_index: expected %0d, actual %0d",
                           $time, want.idx, rsp_ch.bucket_index);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("interval_bucket_search_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                      phase_counts [12];
      int                      cnt;
      int                      n_eff;
      int                      pick;
      int                      step_bits;
      bit                      rebuild;
      bit                      narrow;
      logic [31:0]             r32;
      logic [KEY_W-1:0]        span;
      logic signed [KEY_W-1:0] cursor;
      bucket_req_type          it;

      reset               = 1'b1;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_WRITE;
      req_ch.entry_index  = '0;
      req_ch.low_bound    = '0;
      req_ch.high_bound   = '0;
      req_ch.search_value = '0;
      rsp_ch.ready        = 1'b0;
      errors              = 0;
      idle_pct            = 0;
      stall_pct           = 0;
      bucket_count_reg    = 0;

      // empty table first, then a small sorted table with a gap
      plan_count(0);
      plan_item(CMD_LOOKUP, $urandom_range(TABLE_DEPTH-1), rand_key(), rand_key(), KEY_MIN,
                1, 1'b0, 0);
      plan_item(CMD_LOOKUP, $urandom_range(TABLE_DEPTH-1), rand_key(), rand_key(), KEY_MAX,
                1, 1'b0, 0);
      plan_item(CMD_WRITE, 0, KEY_MIN, -100, rand_key(), 0, 1'b0, 0);
      plan_item(CMD_WRITE, 1, -100, 0, rand_key(), 0, 1'b0, 0);
      plan_item(CMD_WRITE, 2, 10, 1000, rand_key(), 0, 1'b0, 0);
      plan_item(CMD_WRITE, 3, 1000, KEY_MAX, rand_key(), 0, 1'b0, 0);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), 0, 1, 1'b0, 0);
      plan_count(4);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), KEY_MIN, 1, 1'b1, 0);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), KEY_MAX, 1, 1'b0, 0);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), KEY_MAX - 1, 1, 1'b1, 3);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), -100, 0, 1'b0, 0);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), -1, 0, 1'b0, 0);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), 5, 0, 1'b0, 0);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), 10, 0, 1'b0, 0);
      plan_item(CMD_WRITE, TABLE_DEPTH - 1, 2000, 3000, rand_key(), 0, 1'b0, 0);
      plan_count(1);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), -200, 0, 1'b0, 0);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), -100, 1, 1'b0, 0);
      // out-of-order slot: the search must follow its probe order blindly
      plan_item(CMD_WRITE, 1, 5000, 6000, rand_key(), 0, 1'b0, 0);
      plan_count(4);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), 5500, 0, 1'b0, 0);
      plan_item(CMD_LOOKUP, 0, rand_key(), rand_key(), 500, 0, 1'b0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_COUNT) set_bucket_count(plan[i].count_val);
         else send_req(plan[i].item, plan[i].typed, plan[i].want);
      end

      // -1 picks a small random count
      phase_counts = '{2047, 1024, 0, 1, 2, 3, 1023, 1500, -1, -1, -1, -1};
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 71;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 71;
            end
            default: begin
               idle_pct  = 15;
               stall_pct = 15;
            end
         endcase
         cnt = (phase_counts[ph] < 0) ? $urandom_range(4, 48) : phase_counts[ph];
         set_bucket_count(cnt);
         n_eff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;

         rebuild = (n_eff > 0 && n_eff <= 64);
         for (int i = 0; i < n_eff; i++) if (!slot_loaded[i]) rebuild = 1'b1;
         if (rebuild) begin
            // step sizes keep the whole table clear of signed overflow
            narrow    = $urandom_range(1);
            step_bits = narrow ? 10 : 61 - $clog2(n_eff + 1);
            r32       = $urandom;
            if (narrow) cursor = {{32{r32[31]}}, r32};
            else if ($urandom_range(1)) cursor = KEY_MIN;
            else cursor = KEY_MIN + rand_bits(step_bits);
            for (int i = 0; i < n_eff; i++) begin
               it.cmd  = CMD_WRITE;
               it.slot = SLOT_W'(i);
               it.low  = cursor + (($urandom_range(2) == 0) ? 64'd0 : rand_bits(step_bits));
               it.high = it.low + rand_bits(step_bits) + 1;
               if (i == n_eff - 1 && !narrow && $urandom_range(1)) it.high = KEY_MAX;
               it.key  = rand_key();
               cursor  = it.high;
               send_req(it, 1'b0, '0);
            end
         end

         for (int j = 0; j < PHASE_ITEMS; j++) begin
            it.slot = SLOT_W'($urandom_range(TABLE_DEPTH-1));
            it.low  = rand_key();
            it.high = rand_key();
            it.key  = rand_key();
            if ($urandom_range(9) == 0) begin
               it.cmd = CMD_WRITE;
            end else begin
               it.cmd = CMD_LOOKUP;
               if (n_eff > 0) begin
                  pick = $urandom_range(n_eff - 1);
                  case ($urandom_range(8))
                     0: it.key = low_tab[pick];
                     1: it.key = high_tab[pick] - 1;
                     2: it.key = high_tab[pick];
                     3: begin
                        span   = high_tab[pick] - low_tab[pick];
                        it.key = low_tab[pick] + ((span == 0) ? 64'd0 : rand_key() % span);
                     end
                     4: it.key = low_tab[0] - 1;
                     5: it.key = high_tab[n_eff-1];
                     6: begin
                        r32    = $urandom;
                        it.key = {{32{r32[31]}}, r32};
                     end
                     default: ;
                  endcase
               end
            end
            send_req(it, 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("interval_bucket_search_unit: match");
      else $display("interval_bucket_search_unit: mismatch");
      $finish;
   end

endmodule
